FILE: rtl/tcs_pkg.sv
package tcs_pkg;

    localparam int RAW_BITS     = 10;
    localparam int POS_BITS     = 10;
    localparam int SIZE_BITS    = 11;
    localparam int FUNC_BITS    = 3;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [FUNC_BITS-1:0] FUNC_MEASURE   = 3'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_NOISE     = 3'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_MIN_CORNER = 3'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_MAX_CORNER = 3'd3;
    localparam logic [FUNC_BITS-1:0] FUNC_BEGIN_CAL = 3'd4;

    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd1;

    localparam logic [SIZE_BITS-1:0] SCREEN_WIDTH_RST  = 11'd320;
    localparam logic [SIZE_BITS-1:0] SCREEN_HEIGHT_RST = 11'd240;
    localparam logic [RAW_BITS-1:0]  LOW_RST           = RAW_BITS'(200);
    localparam logic [RAW_BITS-1:0]  HIGH_RST          = RAW_BITS'(800);
    localparam logic [RAW_BITS-1:0]  RAW_MAX           = {RAW_BITS{1'b1}};

    typedef struct packed {
        logic [FUNC_BITS-1:0] func;
        logic [RAW_BITS-1:0]  raw_x;
        logic [RAW_BITS-1:0]  raw_y;
    } in_item_t;

    typedef struct packed {
        logic                valid_res;
        logic [POS_BITS-1:0] pos_x;
        logic [POS_BITS-1:0] pos_y;
    } out_item_t;

endpackage

FILE: rtl/touch_coordinate_scaler.sv
// Resistive touch scaler: a measure item that finds a touch with a valid span passes from transfer
// in to result ready through these steps: update the bounds, form offset times screen size, run
// a restoring divider that yields one quotient bit per cycle for both axes at once, and load the
// output register; every other item is taken in and then only loads the output register.
// One item is worked on at a time; a new item may be taken while the last result still waits
// in the output register. Screen size registers are written through the cfg channel, which is
// always ready, and must only change while no item is in flight.
module touch_coordinate_scaler (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  tcs_pkg::in_item_t                    in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output tcs_pkg::out_item_t                   out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tcs_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [tcs_pkg::SIZE_BITS-1:0]        cfg_data
);

    localparam int RB       = tcs_pkg::RAW_BITS;
    localparam int SB       = tcs_pkg::SIZE_BITS;
    localparam int PB       = tcs_pkg::POS_BITS;
    localparam int DIV_BITS = RB + SB;
    localparam int CNT_BITS = $clog2(DIV_BITS);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} state_t;

    typedef struct packed {
        logic [RB-1:0]       rem;
        logic [DIV_BITS-1:0] dvd;
    } div_state_t;

    // one restoring step: quotient bit shifts in at the bottom as the dividend shifts out
    function automatic div_state_t div_step(input div_state_t cur, input logic [RB-1:0] span);
        div_state_t  nxt;
        logic [RB:0]   rem_sh;
        logic [RB+1:0] diff;
        begin
            rem_sh = {cur.rem, cur.dvd[DIV_BITS-1]};
            diff   = {1'b0, rem_sh} - {2'b00, span};
            if (!diff[RB+1])
            begin
                nxt.rem = diff[RB-1:0];
                nxt.dvd = {cur.dvd[DIV_BITS-2:0], 1'b1};
            end
            else
            begin
                nxt.rem = rem_sh[RB-1:0];
                nxt.dvd = {cur.dvd[DIV_BITS-2:0], 1'b0};
            end
            return nxt;
        end
    endfunction

    function automatic logic [PB-1:0] clamp_pos(input logic [DIV_BITS-1:0] q,
                                                 input logic [SB-1:0] size);
        logic [SB-1:0] lim;
        begin
            if (size == '0)
            begin
                lim = '0;
            end
            else if (q >= DIV_BITS'(size))
            begin
                lim = size - SB'(1);
            end
            else
            begin
                lim = q[SB-1:0];
            end
            if (lim > SB'({PB{1'b1}}))
            begin
                return {PB{1'b1}};
            end
            return lim[PB-1:0];
        end
    endfunction

    state_t              state_reg, state_next;
    logic [SB-1:0]       width_reg, width_next;
    logic [SB-1:0]       height_reg, height_next;
    logic [RB-1:0]       low_x_reg, low_x_next, low_y_reg, low_y_next;
    logic [RB-1:0]       high_x_reg, high_x_next, high_y_reg, high_y_next;
    logic [RB-1:0]       floor_x_reg, floor_x_next, floor_y_reg, floor_y_next;
    logic [RB-1:0]       off_x_reg, off_x_next, off_y_reg, off_y_next;
    logic [RB-1:0]       span_x_reg, span_x_next, span_y_reg, span_y_next;
    div_state_t          div_x_reg, div_x_next, div_y_reg, div_y_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    tcs_pkg::out_item_t  res_reg, res_next;
    tcs_pkg::out_item_t  out_data_reg, out_data_next;
    logic                out_valid_reg, out_valid_next;

    logic [RB-1:0] rx, ry;
    logic [RB-1:0] m_low_x, m_high_x, m_low_y, m_high_y;
    div_state_t    step_x, step_y;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign rx = in_data.raw_x;
    assign ry = in_data.raw_y;

    // bounds widened toward a measure sample
    always_comb
    begin
        m_low_x  = low_x_reg;
        m_high_x = high_x_reg;
        m_low_y  = low_y_reg;
        m_high_y = high_y_reg;
        if (rx < low_x_reg)
        begin
            m_low_x = rx;
        end
        else if (rx > high_x_reg)
        begin
            m_high_x = rx;
        end
        if (ry < low_y_reg)
        begin
            m_low_y = ry;
        end
        else if (ry > high_y_reg)
        begin
            m_high_y = ry;
        end
    end

    assign step_x = div_step(div_x_reg, span_x_reg);
    assign step_y = div_step(div_y_reg, span_y_reg);

    always_comb
    begin
        state_next     = state_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        low_x_next     = low_x_reg;
        low_y_next     = low_y_reg;
        high_x_next    = high_x_reg;
        high_y_next    = high_y_reg;
        floor_x_next   = floor_x_reg;
        floor_y_next   = floor_y_reg;
        off_x_next     = off_x_reg;
        off_y_next     = off_y_reg;
        span_x_next    = span_x_reg;
        span_y_next    = span_y_reg;
        div_x_next     = div_x_reg;
        div_y_next     = div_y_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tcs_pkg::REG_SCREEN_WIDTH:  width_next  = cfg_data;
                tcs_pkg::REG_SCREEN_HEIGHT: height_next = cfg_data;
                default: ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_next   = '0;
                    state_next = S_FIN;
                    case (in_data.func) inside
                        tcs_pkg::FUNC_MEASURE:
                        begin
                            if (!(rx < (low_x_reg >> 1) || ry < (low_y_reg >> 1)))
                            begin
                                low_x_next         = m_low_x;
                                high_x_next        = m_high_x;
                                low_y_next         = m_low_y;
                                high_y_next        = m_high_y;
                                res_next.valid_res = 1'b1;
                                if (m_high_x > m_low_x && m_high_y > m_low_y)
                                begin
                                    off_x_next  = rx - m_low_x;
                                    off_y_next  = ry - m_low_y;
                                    span_x_next = m_high_x - m_low_x;
                                    span_y_next = m_high_y - m_low_y;
                                    state_next  = S_MUL;
                                end
                            end
                        end
                        tcs_pkg::FUNC_NOISE:
                        begin
                            if (rx < floor_x_reg)
                            begin
                                floor_x_next = rx;
                            end
                            if (ry < floor_y_reg)
                            begin
                                floor_y_next = ry;
                            end
                            res_next.valid_res = 1'b1;
                        end
                        tcs_pkg::FUNC_MIN_CORNER, tcs_pkg::FUNC_MAX_CORNER:
                        begin
                            // reject corners below twice the noise floor
                            if (!({1'b0, rx} < {floor_x_reg, 1'b0} ||
                                  {1'b0, ry} < {floor_y_reg, 1'b0}))
                            begin
                                res_next.valid_res = 1'b1;
                                if (in_data.func == tcs_pkg::FUNC_MIN_CORNER)
                                begin
                                    if (rx < low_x_reg)
                                    begin
                                        low_x_next = rx;
                                    end
                                    if (ry < low_y_reg)
                                    begin
                                        low_y_next = ry;
                                    end
                                end
                                else
                                begin
                                    if (rx > high_x_reg)
                                    begin
                                        high_x_next = rx;
                                    end
                                    if (ry > high_y_reg)
                                    begin
                                        high_y_next = ry;
                                    end
                                end
                            end
                        end
                        tcs_pkg::FUNC_BEGIN_CAL:
                        begin
                            low_x_next   = tcs_pkg::RAW_MAX;
                            low_y_next   = tcs_pkg::RAW_MAX;
                            high_x_next  = '0;
                            high_y_next  = '0;
                            floor_x_next = tcs_pkg::RAW_MAX;
                            floor_y_next = tcs_pkg::RAW_MAX;
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL:
            begin
                div_x_next.rem = '0;
                div_y_next.rem = '0;
                div_x_next.dvd = DIV_BITS'(off_x_reg * width_reg);
                div_y_next.dvd = DIV_BITS'(off_y_reg * height_reg);
                cnt_next       = CNT_BITS'(DIV_BITS - 1);
                state_next     = S_DIV;
            end
            S_DIV:
            begin
                div_x_next = step_x;
                div_y_next = step_y;
                if (cnt_reg == '0)
                begin
                    res_next.pos_x = clamp_pos(step_x.dvd, width_reg);
                    res_next.pos_y = clamp_pos(step_y.dvd, height_reg);
                    state_next     = S_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_BITS'(1);
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            width_reg     <= tcs_pkg::SCREEN_WIDTH_RST;
            height_reg    <= tcs_pkg::SCREEN_HEIGHT_RST;
            low_x_reg     <= tcs_pkg::LOW_RST;
            low_y_reg     <= tcs_pkg::LOW_RST;
            high_x_reg    <= tcs_pkg::HIGH_RST;
            high_y_reg    <= tcs_pkg::HIGH_RST;
            floor_x_reg   <= tcs_pkg::RAW_MAX;
            floor_y_reg   <= tcs_pkg::RAW_MAX;
            off_x_reg     <= '0;
            off_y_reg     <= '0;
            span_x_reg    <= '0;
            span_y_reg    <= '0;
            div_x_reg     <= '0;
            div_y_reg     <= '0;
            cnt_reg       <= '0;
            res_reg       <= '0;
            out_data_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            low_x_reg     <= low_x_next;
            low_y_reg     <= low_y_next;
            high_x_reg    <= high_x_next;
            high_y_reg    <= high_y_next;
            floor_x_reg   <= floor_x_next;
            floor_y_reg   <= floor_y_next;
            off_x_reg     <= off_x_next;
            off_y_reg     <= off_y_next;
            span_x_reg    <= span_x_next;
            span_y_reg    <= span_y_next;
            div_x_reg     <= div_x_next;
            div_y_reg     <= div_y_next;
            cnt_reg       <= cnt_next;
            res_reg       <= res_next;
            out_data_reg  <= out_data_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // every transfer in moves the state out of idle in the next cycle
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("accepted item did not leave idle");

    // bounds only move on a transfer in
    a_bounds_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> ($stable(low_x_reg) && $stable(high_x_reg) &&
                                   $stable(low_y_reg) && $stable(high_y_reg)))
        else $error("bounds changed while an item was in flight");

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg == '0) |=> (state_reg == S_FIN))
        else $error("divider did not finish on the last step");

    a_rejected_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.valid_res || (out_data.pos_x == '0 && out_data.pos_y == '0)))
        else $error("result without valid_res carries a position");

    a_span_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (span_x_reg != '0 && span_y_reg != '0))
        else $error("division started with a zero span");

endmodule

FILE: dv/tb_touch_coordinate_scaler.sv
`timescale 1ns / 100ps

module tb_touch_coordinate_scaler;

    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int LONG_STALL      = 400;
    localparam int DRAIN_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT  = 5000;

    // indexes past the two screen registers, which the block ignores
    localparam logic [tcs_pkg::CFG_IDX_BITS-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [tcs_pkg::CFG_IDX_BITS-1:0] REG_SPARE_3 = 2'd3;

    // func codes with no meaning, which leave the bounds and noise floor alone
    localparam logic [tcs_pkg::FUNC_BITS-1:0] FUNC_SPARE_5 = 3'd5;
    localparam logic [tcs_pkg::FUNC_BITS-1:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [tcs_pkg::FUNC_BITS-1:0] FUNC_SPARE_7 = 3'd7;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             in_valid  = 1'b0;
    logic                             in_ready;
    tcs_pkg::in_item_t                in_data   = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    tcs_pkg::out_item_t               out_data;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [tcs_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [tcs_pkg::SIZE_BITS-1:0]    cfg_data  = '0;

    tcs_pkg::in_item_t    touch_samples[$];
    tcs_pkg::out_item_t   expected_points[$];

    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    int          stall_requests     = 0;
    int          stall_served       = 0;
    int          stall_left         = 0;
    int          errors             = 0;
    int          quiet_cycles       = 0;
    int          queued_items       = 0;

    // predictor copy of the calibration state and screen size
    logic [tcs_pkg::RAW_BITS-1:0]  lo_x      = tcs_pkg::LOW_RST;
    logic [tcs_pkg::RAW_BITS-1:0]  lo_y      = tcs_pkg::LOW_RST;
    logic [tcs_pkg::RAW_BITS-1:0]  hi_x      = tcs_pkg::HIGH_RST;
    logic [tcs_pkg::RAW_BITS-1:0]  hi_y      = tcs_pkg::HIGH_RST;
    logic [tcs_pkg::RAW_BITS-1:0]  floor_x   = tcs_pkg::RAW_MAX;
    logic [tcs_pkg::RAW_BITS-1:0]  floor_y   = tcs_pkg::RAW_MAX;
    logic [tcs_pkg::SIZE_BITS-1:0] width_sz  = tcs_pkg::SCREEN_WIDTH_RST;
    logic [tcs_pkg::SIZE_BITS-1:0] height_sz = tcs_pkg::SCREEN_HEIGHT_RST;

    int unsigned phase_width [NUM_PHASES];
    int unsigned phase_height[NUM_PHASES];
    int unsigned phase_idle  [NUM_PHASES];
    int unsigned phase_stall [NUM_PHASES];

    touch_coordinate_scaler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic logic [tcs_pkg::POS_BITS-1:0] scale_offset(input int unsigned off,
                                                                  input int unsigned span,
                                                                  input int unsigned size);
        int unsigned q;
        if (size == 0 || span == 0)
            return '0;
        q = (off * size) / span;
        if (q >= size)
            q = size - 1;
        if (q > 1023)
            q = 1023;
        return q[tcs_pkg::POS_BITS-1:0];
    endfunction

    function automatic tcs_pkg::out_item_t predict_point(input tcs_pkg::in_item_t s);
        tcs_pkg::out_item_t r;
        r = '0;
        case (s.func) inside
            tcs_pkg::FUNC_MEASURE:
            begin
                if (!(s.raw_x < (lo_x >> 1) || s.raw_y < (lo_y >> 1)))
                begin
                    if (s.raw_x < lo_x)
                        lo_x = s.raw_x;
                    else if (s.raw_x > hi_x)
                        hi_x = s.raw_x;
                    if (s.raw_y < lo_y)
                        lo_y = s.raw_y;
                    else if (s.raw_y > hi_y)
                        hi_y = s.raw_y;
                    r.valid_res = 1'b1;
                    if (hi_x > lo_x && hi_y > lo_y)
                    begin
                        r.pos_x = scale_offset(s.raw_x - lo_x, hi_x - lo_x, width_sz);
                        r.pos_y = scale_offset(s.raw_y - lo_y, hi_y - lo_y, height_sz);
                    end
                end
            end
            tcs_pkg::FUNC_NOISE:
            begin
                if (s.raw_x < floor_x)
                    floor_x = s.raw_x;
                if (s.raw_y < floor_y)
                    floor_y = s.raw_y;
                r.valid_res = 1'b1;
            end
            tcs_pkg::FUNC_MIN_CORNER, tcs_pkg::FUNC_MAX_CORNER:
            begin
                // corners must sit at least twice the noise floor
                if (!({1'b0, s.raw_x} < {floor_x, 1'b0} || {1'b0, s.raw_y} < {floor_y, 1'b0}))
                begin
                    if (s.func == tcs_pkg::FUNC_MIN_CORNER)
                    begin
                        if (s.raw_x < lo_x)
                            lo_x = s.raw_x;
                        if (s.raw_y < lo_y)
                            lo_y = s.raw_y;
                    end
                    else
                    begin
                        if (s.raw_x > hi_x)
                            hi_x = s.raw_x;
                        if (s.raw_y > hi_y)
                            hi_y = s.raw_y;
                    end
                    r.valid_res = 1'b1;
                end
            end
            tcs_pkg::FUNC_BEGIN_CAL:
            begin
                lo_x    = tcs_pkg::RAW_MAX;
                lo_y    = tcs_pkg::RAW_MAX;
                hi_x    = '0;
                hi_y    = '0;
                floor_x = tcs_pkg::RAW_MAX;
                floor_y = tcs_pkg::RAW_MAX;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int unsigned random_reading();
        case ($urandom_range(3))
            0:       return $urandom_range(0, 31);
            1:       return $urandom_range(992, 1023);
            default: return $urandom_range(0, 1023);
        endcase
    endfunction

    // sender
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            expected_points.push_back(predict_point(in_data));
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (touch_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                in_data  <= touch_samples.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin
        tcs_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_points.size() == 0)
            begin
                $error("unexpected result %p", out_data);
                errors++;
            end
            else
            begin
                want = expected_points.pop_front();
                if (out_data.valid_res !== want.valid_res)
                begin
                    $error("valid_res expected %0d actual %0d", want.valid_res,
                           out_data.valid_res);
                    errors++;
                end
                if (out_data.pos_x !== want.pos_x)
                begin
                    $error("pos_x expected %0d actual %0d", want.pos_x, out_data.pos_x);
                    errors++;
                end
                if (out_data.pos_y !== want.pos_y)
                begin
                    $error("pos_y expected %0d actual %0d", want.pos_y, out_data.pos_y);
                    errors++;
                end
            end
        end
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_served != stall_requests)
        begin
            stall_served <= stall_served + 1;
            stall_left   <= LONG_STALL;
            out_ready    <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic push_sample(input logic [tcs_pkg::FUNC_BITS-1:0] f, input int unsigned x,
                               input int unsigned y);
        tcs_pkg::in_item_t s;
        s.func  = f;
        s.raw_x = tcs_pkg::RAW_BITS'(x);
        s.raw_y = tcs_pkg::RAW_BITS'(y);
        touch_samples.push_back(s);
        if (f <= tcs_pkg::FUNC_BEGIN_CAL)
            queued_items++;
    endtask

    task automatic write_screen_reg(input logic [tcs_pkg::CFG_IDX_BITS-1:0] idx,
                                    input int unsigned value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= tcs_pkg::SIZE_BITS'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == tcs_pkg::REG_SCREEN_WIDTH)
            width_sz = tcs_pkg::SIZE_BITS'(value);
        else if (idx == tcs_pkg::REG_SCREEN_HEIGHT)
            height_sz = tcs_pkg::SIZE_BITS'(value);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (touch_samples.size() != 0 || in_valid || expected_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic queue_measures(input int n);
        repeat (n) push_sample(tcs_pkg::FUNC_MEASURE, random_reading(), random_reading());
    endtask

    // calibration pass; a step may be left out so the pass ends up broken
    task automatic queue_calibration_run();
        int n;
        push_sample(tcs_pkg::FUNC_BEGIN_CAL, $urandom_range(0, 1023), $urandom_range(0, 1023));
        n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3);
        repeat (n)
        begin
            if ($urandom_range(4) == 0)
                push_sample(tcs_pkg::FUNC_NOISE, random_reading(), random_reading());
            else
                push_sample(tcs_pkg::FUNC_NOISE, $urandom_range(0, 60), $urandom_range(0, 60));
        end
        repeat ($urandom_range(0, 3))
            push_sample(tcs_pkg::FUNC_MIN_CORNER, $urandom_range(0, 400),
                        $urandom_range(0, 400));
        repeat ($urandom_range(0, 3))
            push_sample(tcs_pkg::FUNC_MAX_CORNER, $urandom_range(600, 1023),
                        $urandom_range(600, 1023));
        queue_measures($urandom_range(5, 25));
    endtask

    task automatic fill_phase(input int target);
        int start;
        int pick;
        start = queued_items;
        while (queued_items - start < target)
        begin
            pick = $urandom_range(99);
            if (pick < 12)
                push_sample(tcs_pkg::FUNC_BITS'($urandom_range(7)), $urandom_range(0, 1023),
                            $urandom_range(0, 1023));
            else if (pick < 45)
                queue_calibration_run();
            else
                queue_measures($urandom_range(3, 15));
        end
    endtask

    initial
    begin
        phase_width  = '{320, 1, 1024, 0, 2047, 0};
        phase_height = '{240, 1024, 1, 2047, 0, 0};
        phase_idle   = '{0, 68, 0, 12, 0, 68};
        phase_stall  = '{0, 0, 68, 12, 0, 12};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset bounds, edge of the half-minimum test, spare codes
        push_sample(tcs_pkg::FUNC_MEASURE, 0, 0);
        push_sample(tcs_pkg::FUNC_MEASURE, 1023, 1023);
        push_sample(tcs_pkg::FUNC_MEASURE, 200, 200);
        push_sample(tcs_pkg::FUNC_MEASURE, 100, 500);
        push_sample(tcs_pkg::FUNC_MEASURE, 49, 600);
        push_sample(tcs_pkg::FUNC_MEASURE, 512, 511);
        push_sample(FUNC_SPARE_5, 1023, 1023);
        push_sample(FUNC_SPARE_6, 0, 1023);
        push_sample(FUNC_SPARE_7, 1023, 0);
        push_sample(tcs_pkg::FUNC_NOISE, 1023, 1023);
        // full-range calibration
        push_sample(tcs_pkg::FUNC_BEGIN_CAL, 0, 0);
        push_sample(tcs_pkg::FUNC_MEASURE, 300, 300);
        push_sample(tcs_pkg::FUNC_NOISE, 0, 0);
        push_sample(tcs_pkg::FUNC_MIN_CORNER, 0, 0);
        push_sample(tcs_pkg::FUNC_MAX_CORNER, 1023, 1023);
        push_sample(tcs_pkg::FUNC_MEASURE, 1023, 1023);
        push_sample(tcs_pkg::FUNC_MEASURE, 0, 0);
        push_sample(tcs_pkg::FUNC_MEASURE, 512, 511);
        // corner below twice the floor, then a zero span
        push_sample(tcs_pkg::FUNC_BEGIN_CAL, 1023, 1023);
        push_sample(tcs_pkg::FUNC_NOISE, 300, 300);
        push_sample(tcs_pkg::FUNC_MIN_CORNER, 599, 700);
        push_sample(tcs_pkg::FUNC_MIN_CORNER, 600, 600);
        push_sample(tcs_pkg::FUNC_MAX_CORNER, 600, 600);
        push_sample(tcs_pkg::FUNC_MEASURE, 600, 600);
        push_sample(tcs_pkg::FUNC_MAX_CORNER, 1023, 1023);
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p == NUM_PHASES - 1)
            begin
                write_screen_reg(tcs_pkg::REG_SCREEN_WIDTH, $urandom_range(1, 1024));
                write_screen_reg(tcs_pkg::REG_SCREEN_HEIGHT, $urandom_range(1, 1024));
            end
            else
            begin
                write_screen_reg(tcs_pkg::REG_SCREEN_WIDTH, phase_width[p]);
                write_screen_reg(tcs_pkg::REG_SCREEN_HEIGHT, phase_height[p]);
            end
            if (p == 4)
            begin
                write_screen_reg(REG_SPARE_2, $urandom_range(0, 2047));
                write_screen_reg(REG_SPARE_3, $urandom_range(0, 2047));
            end
            sender_idle_pct    = phase_idle[p];
            receiver_stall_pct = phase_stall[p];
            fill_phase(ITEMS_PER_PHASE);
            // output held off while the sender keeps offering, so the input backs up
            if (p == 4)
                stall_requests++;
            drain();
        end

        if (errors == 0 && expected_points.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
